### src/hbd_pkg.sv
// Shared types, constants and helpers for the HTTP body deframer.
package hbd_pkg;

    localparam int MAX_SIZE_LINE = 64;
    localparam int LINE_CNT_W    = $clog2(MAX_SIZE_LINE * 2);
    localparam logic [LINE_CNT_W-1:0] LINE_LIMIT = LINE_CNT_W'(MAX_SIZE_LINE - 2);

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // Largest chunk size that still leaves room for the trailing CR LF.
    localparam logic [31:0] SIZE_MAX = 32'hFFFF_FFFD;

    typedef enum logic [1:0] {
        MODE_LENGTH  = 2'd0,
        MODE_CHUNKED = 2'd1
    } mode_t;

    typedef enum logic [0:0] {
        REG_TRANSFER_MODE = 1'b0,
        REG_BODY_LENGTH   = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_LF       = 2'd1,
        ST_OVERFLOW    = 2'd2,
        ST_UNSUPPORTED = 2'd3
    } status_t;

    typedef enum logic [6:0] {
        PH_IDLE  = 7'b000_0001,
        PH_LEN   = 7'b000_0010,
        PH_LINE  = 7'b000_0100,
        PH_LF    = 7'b000_1000,
        PH_CHUNK = 7'b001_0000,
        PH_DONE  = 7'b010_0000,
        PH_ERR   = 7'b100_0000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } hbd_in_t;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       has_data;
        logic       body_end;
        status_t    status;
    } hbd_out_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c >= 8'd48 && c <= 8'd57) begin
            h.value = 4'(c - 8'd48);
        end else if (c >= 8'd65 && c <= 8'd70) begin
            h.value = 4'(c - 8'd55);
        end else if (c >= 8'd97 && c <= 8'd102) begin
            h.value = 4'(c - 8'd87);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

### src/hbd_framer.sv
// Framing state machine: one state update and at most one result per beat.
module hbd_framer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  hbd_pkg::hbd_in_t beat,
    input  logic [1:0]      transfer_mode,
    input  logic [31:0]     body_length,
    output logic            res_valid,
    output hbd_pkg::hbd_out_t res
);
    import hbd_pkg::*;

    phase_t                phase_reg, phase_next;
    logic [31:0]           bytes_left_reg, bytes_left_next;
    logic [31:0]           size_accum_reg, size_accum_next;
    logic [LINE_CNT_W-1:0] line_count_reg, line_count_next;

    logic                  emit;
    hbd_out_t              emit_data;

    always_comb
    begin
        phase_t                ph;
        logic [31:0]           left;
        logic [31:0]           accum;
        logic [LINE_CNT_W-1:0] line;
        logic                  handled;
        logic [31:0]           left_dec;
        hex_digit_t            hd;
        logic [35:0]           shifted;

        ph       = phase_reg;
        left     = bytes_left_reg;
        accum    = size_accum_reg;
        line     = line_count_reg;
        handled  = 1'b0;
        emit     = 1'b0;
        emit_data = '{body_byte: 8'd0, has_data: 1'b0, body_end: 1'b0, status: ST_OK};

        if (beat.first_byte) begin
            left  = 32'd0;
            accum = 32'd0;
            line  = '0;
            case (transfer_mode)
                MODE_LENGTH:
                begin
                    if (body_length == 32'd0) begin
                        ph = PH_DONE;
                        handled = 1'b1;
                        emit = 1'b1;
                        emit_data.body_end = 1'b1;
                    end else begin
                        ph   = PH_LEN;
                        left = body_length;
                    end
                end
                MODE_CHUNKED:
                begin
                    ph = PH_LINE;
                end
                default:
                begin
                    ph = PH_ERR;
                    handled = 1'b1;
                    emit = 1'b1;
                    emit_data.body_end = 1'b1;
                    emit_data.status   = ST_UNSUPPORTED;
                end
            endcase
        end

        left_dec = left - 32'd1;
        hd       = hex_decode(beat.data_byte);
        shifted  = {accum, hd.value};

        if (!handled) begin
            case (ph)
                PH_LEN:
                begin
                    left = left_dec;
                    emit = 1'b1;
                    emit_data.body_byte = beat.data_byte;
                    emit_data.has_data  = 1'b1;
                    if (left_dec == 32'd0) begin
                        ph = PH_DONE;
                        emit_data.body_end = 1'b1;
                    end
                end
                PH_LINE:
                begin
                    if (beat.data_byte == CHAR_CR) begin
                        ph = PH_LF;
                    end else if (line >= LINE_LIMIT) begin
                        ph = PH_ERR;
                        emit = 1'b1;
                        emit_data.body_end = 1'b1;
                        emit_data.status   = ST_OVERFLOW;
                    end else begin
                        line = line + 1'b1;
                        if (hd.ok) begin
                            // Overflow when anything lands above bit 31 or
                            // the low word exceeds the size ceiling.
                            if (shifted[35:32] != 4'd0 || shifted[31:0] > SIZE_MAX) begin
                                ph = PH_ERR;
                                emit = 1'b1;
                                emit_data.body_end = 1'b1;
                                emit_data.status   = ST_OVERFLOW;
                            end else begin
                                accum = shifted[31:0];
                            end
                        end
                    end
                end
                PH_LF:
                begin
                    if (beat.data_byte != CHAR_LF) begin
                        ph = PH_ERR;
                        emit = 1'b1;
                        emit_data.body_end = 1'b1;
                        emit_data.status   = ST_NO_LF;
                    end else if (accum == 32'd0) begin
                        ph = PH_DONE;
                        emit = 1'b1;
                        emit_data.body_end = 1'b1;
                    end else begin
                        // data bytes plus the trailing CR LF
                        left = accum + 32'd2;
                        ph   = PH_CHUNK;
                    end
                end
                PH_CHUNK:
                begin
                    left = left_dec;
                    emit = 1'b1;
                    emit_data.body_byte = beat.data_byte;
                    emit_data.has_data  = 1'b1;
                    if (left_dec == 32'd0) begin
                        ph    = PH_LINE;
                        accum = 32'd0;
                        line  = '0;
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end

        phase_next      = ph;
        bytes_left_next = left;
        size_accum_next = accum;
        line_count_next = line;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg      <= PH_IDLE;
            bytes_left_reg <= 32'd0;
            size_accum_reg <= 32'd0;
            line_count_reg <= '0;
        end else if (step) begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            size_accum_reg <= size_accum_next;
            line_count_reg <= line_count_next;
        end
    end

    assign res_valid = step && emit;
    assign res       = emit_data;

endmodule

### src/http_body_deframer.sv
// Top level of the HTTP body deframer: config registers, framer, output buffer.
//
// Usage notes:
// - Input channel (in_valid/in_ready/in_data) carries one received byte per
//   beat; first_byte marks the first body byte and restarts the framer,
//   sampling transfer_mode and body_length at that beat.
// - Output channel (out_valid/out_ready/out_data) carries at most one result
//   beat per input beat: a body byte, an end marker, or an error status.
// - Config port: cfg_we writes cfg_data into register cfg_index
//   (0 transfer_mode, 1 body_length) at the clock edge, no wait.
// - An accepted beat's result is registered in the output register, or in the
//   skid entry while that register is still held. Throughput: one byte per
//   cycle while in_ready is high, set by a single framer state update per beat.
// - Stall: a two-entry output buffer (output register plus skid) lets one
//   input beat be taken while a result waits; in_ready drops only once the
//   skid entry is occupied.
// - Reset: rst_n clears the framer to idle, the registers to zero and
//   empties the output buffer; bytes before a first_byte are ignored.
module http_body_deframer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  hbd_pkg::hbd_in_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output hbd_pkg::hbd_out_t  out_data,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import hbd_pkg::*;

    logic [1:0]  transfer_mode_reg;
    logic [31:0] body_length_reg;

    logic        step;
    logic        res_valid;
    hbd_out_t    res;

    logic        out_valid_reg;
    hbd_out_t    out_data_reg;
    logic        skid_valid_reg;
    hbd_out_t    skid_data_reg;
    logic        pop;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            transfer_mode_reg <= 2'd0;
            body_length_reg   <= 32'd0;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_index))
                REG_TRANSFER_MODE: transfer_mode_reg <= cfg_data[1:0];
                REG_BODY_LENGTH:   body_length_reg   <= cfg_data;
                default:           body_length_reg   <= body_length_reg;
            endcase
        end
    end

    assign in_ready = !skid_valid_reg;
    assign step     = in_valid && in_ready;

    hbd_framer u_framer (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .beat          (in_data),
        .transfer_mode (transfer_mode_reg),
        .body_length   (body_length_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    // Output register with skid entry behind it
    assign pop = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                // no new beats while skid is full
                if (pop) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end else if (res_valid) begin
                if (!out_valid_reg || pop) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (res_valid) begin
            if (!out_valid_reg || pop) begin
                out_data_reg <= res;
            end else begin
                skid_data_reg <= res;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the HTTP body deframer: directed and random byte streams.
`timescale 1ns / 1ps

module tb_top;
    import hbd_pkg::*;

    // Encodings the package has no name for: both select the unsupported path
    localparam logic [1:0] MODE_UNSUP_2 = 2'd2;
    localparam logic [1:0] MODE_UNSUP_3 = 2'd3;

    // ASCII hex digit bounds
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_A_UP = 8'h41;
    localparam logic [7:0] CH_F_UP = 8'h46;
    localparam logic [7:0] CH_A_LO = 8'h61;
    localparam logic [7:0] CH_F_LO = 8'h66;

    localparam int RANDOM_ITEMS  = 750;
    localparam int HOLD_CYCLES   = 60;   // long receiver hold-off for the back-pressure test
    localparam int SETTLE_CYCLES = 4;    // margin for the registered output and the two-entry output buffer
    localparam int WATCHDOG_MAX  = 2000; // cycles without any beat on either channel

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    hbd_in_t     in_data;
    logic        out_valid;
    logic        out_ready;
    hbd_out_t    out_data;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_data;

    http_body_deframer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the framer: register copies and framing state, updated
    // once per accepted input beat.
    // ------------------------------------------------------------------
    logic [1:0]  cur_mode;
    logic [31:0] cur_len;
    phase_t      fr_phase;
    logic [31:0] left_cnt;
    logic [31:0] size_acc;
    int          line_cnt;

    hbd_out_t    due_results[$];  // results the framer still owes, oldest first
    int          n_err;
    int          n_framed;        // beats the framer actually acted on
    bit          no_idle;         // both sides run flat out while set
    int unsigned hold_requests;
    int unsigned hold_served;
    int unsigned rx_wait;
    int          quiet_cycles;

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9)
            return int'(c - CH_0);
        if (c >= CH_A_UP && c <= CH_F_UP)
            return int'(c - CH_A_UP) + 10;
        if (c >= CH_A_LO && c <= CH_F_LO)
            return int'(c - CH_A_LO) + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
        if (nib < 4'd10)
            return CH_0 + 8'(nib);
        return (upper ? CH_A_UP : CH_A_LO) + 8'(nib) - 8'd10;
    endfunction

    // Any byte that neither adds a digit nor closes the size line
    function automatic logic [7:0] junk_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (hex_nibble(c) >= 0 || c == CHAR_CR);
        return c;
    endfunction

    function automatic hbd_out_t error_beat(input status_t st);
        hbd_out_t r;
        r          = '0;
        r.body_end = 1'b1;
        r.status   = st;
        fr_phase   = PH_ERR;
        return r;
    endfunction

    // Advance the shadow framer by one byte; returns 1 when a result is due.
    function automatic bit deframe_byte(input logic [7:0] c, input logic first,
                                        output hbd_out_t r);
        int          d;
        logic [35:0] grown;
        r = '0;
        if (first)
        begin
            left_cnt = '0;
            size_acc = '0;
            line_cnt = 0;
            if (cur_mode == MODE_LENGTH)
            begin
                // empty body: the first byte is not body, just the end marker
                if (cur_len == '0)
                begin
                    fr_phase   = PH_DONE;
                    r.body_end = 1'b1;
                    return 1'b1;
                end
                fr_phase = PH_LEN;
                left_cnt = cur_len;
            end
            else if (cur_mode == MODE_CHUNKED)
                fr_phase = PH_LINE;
            else
            begin
                r = error_beat(ST_UNSUPPORTED);
                return 1'b1;
            end
        end

        case (fr_phase)
            PH_LEN:
            begin
                left_cnt    = left_cnt - 32'd1;
                r.body_byte = c;
                r.has_data  = 1'b1;
                if (left_cnt == '0)
                begin
                    fr_phase   = PH_DONE;
                    r.body_end = 1'b1;
                end
                return 1'b1;
            end
            PH_LINE:
            begin
                if (c == CHAR_CR)
                begin
                    fr_phase = PH_LF;
                    return 1'b0;
                end
                if (line_cnt >= MAX_SIZE_LINE - 2)
                begin
                    r = error_beat(ST_OVERFLOW);
                    return 1'b1;
                end
                line_cnt++;
                d = hex_nibble(c);
                if (d >= 0)
                begin
                    // size * 16 + digit, checked against the room left for CR LF
                    grown = {size_acc, 4'(d)};
                    if (grown > 36'(SIZE_MAX))
                    begin
                        r = error_beat(ST_OVERFLOW);
                        return 1'b1;
                    end
                    size_acc = grown[31:0];
                end
                return 1'b0;
            end
            PH_LF:
            begin
                if (c != CHAR_LF)
                begin
                    r = error_beat(ST_NO_LF);
                    return 1'b1;
                end
                if (size_acc == '0)
                begin
                    fr_phase   = PH_DONE;
                    r.body_end = 1'b1;
                    return 1'b1;
                end
                left_cnt = size_acc + 32'd2;  // data plus the two bytes that follow
                fr_phase = PH_CHUNK;
                return 1'b0;
            end
            PH_CHUNK:
            begin
                left_cnt = left_cnt - 32'd1;
                if (left_cnt == '0)
                begin
                    fr_phase = PH_LINE;
                    size_acc = '0;
                    line_cnt = 0;
                end
                r.body_byte = c;
                r.has_data  = 1'b1;
                return 1'b1;
            end
            default:
                return 1'b0;  // idle, done or error: byte ignored
        endcase
    endfunction

    // Mostly back-to-back, some short gaps, the odd long one
    function automatic int pick_gap();
        int roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------
    // Sender: one byte per call. Valid is only dropped when a gap is
    // taken, so back-to-back beats never see valid lowered and raised in
    // the same time step.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] c, input logic first);
        int       gap;
        hbd_out_t r;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {c, first};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (first || fr_phase inside {PH_LEN, PH_LINE, PH_LF, PH_CHUNK})
            n_framed++;
        if (deframe_byte(c, first, r))
            due_results.push_back(r);
    endtask

    // Wait for the framer to go quiet: every result out, then a settling wait
    // in case the last byte was one that produces nothing.
    task automatic settle();
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_TRANSFER_MODE)
            cur_mode = val[1:0];
        else
            cur_len = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hex size line with optional leading zeros, mixed case and an
    // extension of non-hex bytes, closed by CR LF.
    task automatic send_size_line(input logic [31:0] chunk_len, input bit lead);
        int n_dig;
        int n_zero;
        bit is_first;
        n_dig = 1;
        while (n_dig < 8 && (chunk_len >> (4 * n_dig)) != 0)
            n_dig++;
        n_zero   = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
        is_first = lead;
        repeat (n_zero)
        begin
            send_byte(CH_0, is_first);
            is_first = 1'b0;
        end
        for (int i = n_dig - 1; i >= 0; i--)
        begin
            send_byte(hex_char(chunk_len[4 * i +: 4], $urandom_range(0, 1)), is_first);
            is_first = 1'b0;
        end
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) send_byte(junk_byte(), 1'b0);
        send_byte(CHAR_CR, 1'b0);
        send_byte(CHAR_LF, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request counted
    // here so the sender keeps pushing while the output buffer fills.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_served != hold_requests)
            begin
                hold_served++;
                rx_wait = HOLD_CYCLES;
            end
            if (rx_wait > 0)
            begin
                out_ready <= 1'b0;
                rx_wait--;
            end
            else
            begin
                out_ready <= 1'b1;
                rx_wait = pick_gap();
            end
        end
    end

    function automatic void check_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            n_err++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endfunction

    // Result checker: every output beat against the oldest expectation
    always @(posedge clk)
    begin
        hbd_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (due_results.size() == 0)
            begin
                n_err++;
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, out_data);
            end
            else
            begin
                want = due_results.pop_front();
                check_field("body_byte", want.body_byte, out_data.body_byte);
                check_field("has_data", want.has_data, out_data.has_data);
                check_field("body_end", want.body_end, out_data.body_end);
                check_field("status", want.status, out_data.status);
            end
        end
    end

    // Watchdog: a run that stops moving is a failure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_MAX)
            begin
                $display("%0t: watchdog expired, %0d results outstanding", $time,
                         due_results.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Out of reset: stray bytes are ignored, and the reset length of zero
    // gives an empty body on the first beat.
    task automatic test_idle_and_empty();
        send_byte(8'h55, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
    endtask

    // Length-delimited: extremes of the data byte, a restart part-way
    // through a body, bytes after the end ignored.
    task automatic test_length_body();
        write_reg(REG_TRANSFER_MODE, MODE_LENGTH);
        write_reg(REG_BODY_LENGTH, 32'd2);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h11, 1'b1);
        send_byte(8'h22, 1'b1);
        send_byte(8'h33, 1'b0);
        // largest length: a few beats, then left open
        write_reg(REG_BODY_LENGTH, 32'hFFFF_FFFF);
        send_byte(8'h80, 1'b1);
        send_byte(8'h7F, 1'b0);
    endtask

    task automatic test_unsupported();
        write_reg(REG_TRANSFER_MODE, MODE_UNSUP_2);
        send_byte(8'h31, 1'b1);
        send_byte(8'h32, 1'b0);
        write_reg(REG_TRANSFER_MODE, MODE_UNSUP_3);
        send_byte(8'h33, 1'b1);
    endtask

    // "1;" size line with a skipped extension byte, one data byte and its
    // CR LF, then the zero-size line closing the body.
    task automatic test_chunked_body();
        write_reg(REG_TRANSFER_MODE, MODE_CHUNKED);
        send_byte(CH_0 + 8'd1, 1'b1);
        send_byte(8'h3B, 1'b0);
        send_byte(CHAR_CR, 1'b0);
        send_byte(CHAR_LF, 1'b0);
        send_byte(8'h58, 1'b0);
        send_byte(CHAR_CR, 1'b0);
        send_byte(CHAR_LF, 1'b0);
        send_byte(CH_0, 1'b0);
        send_byte(CHAR_CR, 1'b0);
        send_byte(CHAR_LF, 1'b0);
        send_byte(CHAR_CR, 1'b0);
    endtask

    task automatic test_cr_without_lf();
        send_byte(CH_0 + 8'd5, 1'b1);
        send_byte(CHAR_CR, 1'b0);
        send_byte(CH_A_UP, 1'b0);
    endtask

    // 0xFFFFFFFE is one past the largest size; 0xFFFFFFFD still fits
    task automatic test_size_limit();
        send_byte(CH_F_LO, 1'b1);
        repeat (6) send_byte(CH_F_UP, 1'b0);
        send_byte(CH_A_UP + 8'd4, 1'b0);
        send_size_line(SIZE_MAX, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFE, 1'b0);
    endtask

    // Size line of exactly the allowed length, then one byte too many
    task automatic test_long_line();
        for (int i = 0; i < MAX_SIZE_LINE - 2; i++)
            send_byte(CH_0, i == 0);
        send_byte(CHAR_CR, 1'b0);
        send_byte(CHAR_LF, 1'b0);
        for (int i = 0; i < MAX_SIZE_LINE - 1; i++)
            send_byte(CH_0, i == 0);
    endtask

    // Receiver holds off while a body streams in flat out: the output
    // buffer fills and in_ready must drop.
    task automatic test_backpressure();
        write_reg(REG_TRANSFER_MODE, MODE_LENGTH);
        write_reg(REG_BODY_LENGTH, 32'd24);
        no_idle = 1'b1;
        hold_requests++;
        for (int i = 0; i < 24; i++)
            send_byte(8'($urandom_range(0, 255)), i == 0);
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Random traffic
    // ------------------------------------------------------------------
    task automatic random_length_body();
        logic [31:0] len;
        int          roll;
        int          n_send;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            len = '0;
        else if (roll < 85)
            len = $urandom_range(1, 16);
        else if (roll < 96)
            len = $urandom_range(17, 64);
        else
            len = 32'hFFFF_FFFF;
        if (cur_mode != MODE_LENGTH)
            write_reg(REG_TRANSFER_MODE, MODE_LENGTH);
        if (len != cur_len)
            write_reg(REG_BODY_LENGTH, len);
        n_send = (len == '0) ? 1 : ((len > 32'd64) ? $urandom_range(1, 6) : int'(len));
        // now and then the body is cut short by the next restart
        if ($urandom_range(0, 9) == 0)
            n_send = $urandom_range(1, n_send);
        for (int i = 0; i < n_send; i++)
            send_byte(8'($urandom_range(0, 255)), i == 0);
    endtask

    task automatic random_chunked_body();
        int n_chunks;
        int chunk_len;
        int roll;
        bit lead;
        logic [7:0] c;
        if (cur_mode != MODE_CHUNKED)
            write_reg(REG_TRANSFER_MODE, MODE_CHUNKED);
        n_chunks = $urandom_range(0, 3);
        lead     = 1'b1;
        for (int k = 0; k < n_chunks; k++)
        begin
            chunk_len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8)
                                                   : $urandom_range(9, 40);
            send_size_line(chunk_len, lead);
            lead = 1'b0;
            repeat (chunk_len) send_byte(8'($urandom_range(0, 255)), 1'b0);
            // the two bytes after the data are forwarded whatever they hold
            if ($urandom_range(0, 3) != 0)
            begin
                send_byte(CHAR_CR, 1'b0);
                send_byte(CHAR_LF, 1'b0);
            end
            else
                repeat (2) send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        roll = $urandom_range(0, 19);
        if (roll < 14)
            send_size_line(0, lead);
        else if (roll < 16)
        begin
            // CR not followed by LF
            send_byte(hex_char(4'($urandom_range(0, 15)), $urandom_range(0, 1)), lead);
            send_byte(CHAR_CR, 1'b0);
            do
                c = 8'($urandom_range(0, 255));
            while (c == CHAR_LF);
            send_byte(c, 1'b0);
        end
        else if (roll < 18)
        begin
            // overlong size line
            for (int i = 0; i < MAX_SIZE_LINE - 1; i++)
                send_byte(($urandom_range(0, 3) == 0) ? junk_byte() : CH_0, lead && i == 0);
        end
        else if (roll < 19)
        begin
            // nine significant digits cannot fit
            for (int i = 0; i < 9; i++)
                send_byte(hex_char(4'($urandom_range(1, 15)), $urandom_range(0, 1)),
                          lead && i == 0);
        end
        else
        begin
            // largest legal size, left open after a few data bytes
            send_size_line(SIZE_MAX, lead);
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic test_random_traffic();
        int goal;
        int roll;
        goal = n_framed + RANDOM_ITEMS;
        while (n_framed < goal)
        begin
            if ($urandom_range(0, 7) == 0)
                no_idle = !no_idle;
            roll = $urandom_range(0, 99);
            if (roll < 50)
                random_chunked_body();
            else if (roll < 88)
                random_length_body();
            else if (roll < 93)
            begin
                write_reg(REG_TRANSFER_MODE, $urandom_range(0, 1) ? MODE_UNSUP_2 : MODE_UNSUP_3);
                send_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            else if (roll < 96)
                write_reg(REG_BODY_LENGTH, $urandom);
            else
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            // stray bytes after the body, mostly ignored
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        out_ready     = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_TRANSFER_MODE;
        cfg_data      = '0;
        cur_mode      = MODE_LENGTH;
        cur_len       = '0;
        fr_phase      = PH_IDLE;
        left_cnt      = '0;
        size_acc      = '0;
        line_cnt      = 0;
        n_err         = 0;
        n_framed      = 0;
        no_idle       = 1'b0;
        hold_requests = 0;
        hold_served   = 0;
        rx_wait       = 0;
        quiet_cycles  = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_idle_and_empty();
        test_length_body();
        test_unsupported();
        test_chunked_body();
        test_cr_without_lf();
        test_size_limit();
        test_long_line();
        test_backpressure();
        test_random_traffic();

        settle();
        repeat (10) @(posedge clk);
        if (n_err == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
